// ===== hdl/mh2_pkg.sv =====
// Package for the MurmurHash2 bucket block: payload structs, sequencer states,
// register indexes and the hash constants. No dependencies.
package mh2_pkg;

  localparam logic [31:0] MUR_MUL = 32'h5bd1e995;
  localparam int unsigned SHIFT_K = 24;
  localparam int unsigned SHIFT_A = 13;
  localparam int unsigned SHIFT_B = 15;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_HASH_SEED    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_LIMIT = 2'd1;

  localparam logic [2:0] FULL_WORD = 3'd4;

  typedef struct packed {
    logic [31:0] key_word;
    logic [2:0]  word_bytes;
    logic [15:0] key_length;
    logic        first_word;
    logic        last_word;
  } key_req_t;

  typedef struct packed {
    logic [31:0] hash_value;
    logic [15:0] bucket_index;
  } hash_res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MK1,
    S_MK2,
    S_MH,
    S_TAIL,
    S_FIN,
    S_DIV,
    S_DONE
  } mh2_state_t;

endpackage

// ===== hdl/murmur2_hash_bucket.sv =====
// MurmurHash2 (32 bit) over a key of little-endian words, reduced to a bucket.
// Uses mh2_pkg for payload structs, states and constants.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-----------------------------
//   key     | in        | key_valid / key_ready  | key_req  (key_req_t)
//   hash    | out       | hash_valid / hash_ready| hash_res (hash_res_t)
//   cfg     | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One 32x32 multiplier (low half, by the fixed constant) is reused by the sequencer.
// A non-last word runs S_MK1, S_MK2 and S_MH before the next word can be taken.
// A last word runs S_MK1, S_MK2 and S_MH (full word), S_TAIL (1 to 3 bytes) or
// neither, then S_FIN, the bit-serial remainder in S_DIV and the hand-off in S_DONE.
// Reset is synchronous and clears the sequencer, key flag, configuration registers and result valid flag.
// A stalled result holds in the output register while the next key runs; its result waits.
module murmur2_hash_bucket
  import mh2_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 key_valid,
  output logic                 key_ready,
  input  key_req_t             key_req,
  output logic                 hash_valid,
  input  logic                 hash_ready,
  output hash_res_t            hash_res,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  mh2_state_t  state, state_next;
  logic [31:0] hash_seed;
  logic [15:0] bucket_limit;
  logic [31:0] h;
  logic [31:0] k;
  logic [31:0] w;
  logic [2:0]  nb;
  logic        last;
  logic        in_key;
  logic [4:0]  cnt;
  logic [16:0] rem;

  logic        key_acc;
  logic        res_load;
  logic [2:0]  req_nb;
  logic [31:0] tail_bits;
  logic [31:0] mul_a;
  logic [31:0] prod;
  logic [16:0] divisor;
  logic [17:0] trial;

  assign key_acc = key_valid && key_ready;
  assign cfg_ready = 1'b1;

  // Saturate the byte count of a last word to a full word
  assign req_nb = (key_req.word_bytes > FULL_WORD) ? FULL_WORD : key_req.word_bytes;

  // Gather the tail bytes of a short last word
  always_comb begin
    tail_bits = 32'd0;
    if (nb == 3'd3) begin
      tail_bits[23:16] = w[23:16];
    end
    if (nb >= 3'd2) begin
      tail_bits[15:8] = w[15:8];
    end
    if (nb >= 3'd1) begin
      tail_bits[7:0] = w[7:0];
    end
  end

  // Select the operand of the shared multiplier
  always_comb begin
    case (state)
      S_MK1:   mul_a = w;
      S_MK2:   mul_a = k;
      S_MH:    mul_a = h;
      S_TAIL:  mul_a = h ^ tail_bits;
      S_FIN:   mul_a = h ^ (h >> SHIFT_A);
      default: mul_a = 32'd0;
    endcase
  end

  assign prod = mul_a * MUR_MUL;

  // One restoring step of the bucket remainder
  assign divisor = {1'b0, bucket_limit} + 17'd1;
  assign trial   = {rem, h[cnt]};

  // Sequence the multiplier steps, the remainder and the result hand-off
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (key_acc) begin
          if (!key_req.last_word || req_nb == FULL_WORD) begin
            state_next = S_MK1;
          end else if (req_nb != 3'd0) begin
            state_next = S_TAIL;
          end else begin
            state_next = S_FIN;
          end
        end
      end
      S_MK1:  state_next = S_MK2;
      S_MK2:  state_next = S_MH;
      S_MH:   state_next = last ? S_FIN : S_IDLE;
      S_TAIL: state_next = S_FIN;
      S_FIN:  state_next = S_DIV;
      S_DIV: begin
        if (cnt == 5'd0) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!hash_valid || hash_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Drive the handshake outputs of the sequencer
  always_comb begin
    key_ready = 1'b0;
    res_load  = 1'b0;
    case (state)
      S_IDLE:  key_ready = 1'b1;
      S_DONE:  res_load  = !hash_valid || hash_ready;
      default: begin
        key_ready = 1'b0;
        res_load  = 1'b0;
      end
    endcase
  end

  // Hold control state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      in_key       <= 1'b0;
      hash_valid   <= 1'b0;
      hash_seed    <= 32'd0;
      bucket_limit <= 16'd0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_HASH_SEED) begin
          hash_seed <= cfg_data;
        end else if (cfg_index == CFG_BUCKET_LIMIT) begin
          bucket_limit <= cfg_data[15:0];
        end
      end
      if (key_acc) begin
        in_key <= 1'b1;
      end else if (state == S_FIN) begin
        in_key <= 1'b0;
      end
      if (res_load) begin
        hash_valid <= 1'b1;
      end else if (hash_ready) begin
        hash_valid <= 1'b0;
      end
    end
  end

  // Advance the datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (key_acc) begin
          w    <= key_req.key_word;
          last <= key_req.last_word;
          nb   <= key_req.last_word ? req_nb : FULL_WORD;
          if (key_req.first_word || !in_key) begin
            h <= hash_seed ^ {16'd0, key_req.key_length};
          end
        end
      end
      S_MK1:  k <= prod ^ (prod >> SHIFT_K);
      S_MK2:  k <= prod;
      S_MH:   h <= prod ^ k;
      S_TAIL: h <= prod;
      S_FIN: begin
        h   <= prod ^ (prod >> SHIFT_B);
        rem <= 17'd0;
        cnt <= 5'd31;
      end
      S_DIV: begin
        if (trial >= {1'b0, divisor}) begin
          rem <= 17'(trial - {1'b0, divisor});
        end else begin
          rem <= trial[16:0];
        end
        cnt <= cnt - 5'd1;
      end
      default: begin
        k <= k;
      end
    endcase
    if (res_load) begin
      hash_res.hash_value   <= h;
      hash_res.bucket_index <= rem[15:0];
    end
  end

endmodule

// ===== hdl/mh2_checker.sv =====
// Port-level checks for murmur2_hash_bucket, attached by the bind below.
// Uses mh2_pkg for the result payload type.
module mh2_checker
  import mh2_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 key_valid,
  input logic                 key_ready,
  input logic                 hash_valid,
  input logic                 hash_ready,
  input hash_res_t            hash_res
);

  // No result is pending right after reset
  a_reset_clear: assert property (@(posedge clk) rst |=> !hash_valid)
    else $error("result valid after reset");

  // The block is busy in the cycle after it takes a key request
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    (key_valid && key_ready) |=> !key_ready)
    else $error("key request taken in back-to-back cycles");

  // A new result appears only after a busy cycle of the sequencer
  a_result_after_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(hash_valid) |-> $past(!key_ready))
    else $error("result appeared while the sequencer was idle");

  // A stalled result holds its value
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (hash_valid && !hash_ready) |=> (hash_valid && $stable(hash_res)))
    else $error("stalled result changed");

endmodule

bind murmur2_hash_bucket mh2_checker u_mh2_checker (.*);
